>>> rtl/mlrf_pkg.sv
`timescale 1ns / 1ps

package mlrf_pkg;

	// frame and header geometry
	localparam int MAX_FRAME_BYTES = 2048;
	localparam int MAX_SKIP        = 8;
	localparam int STORE_DEPTH     = 50;
	localparam int STACK_START     = 14;
	localparam int QUEUE_DEPTH     = 4;

	localparam int POS_W  = $clog2(MAX_FRAME_BYTES + 1);
	localparam int SIDX_W = $clog2(STORE_DEPTH);
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] ETHTYPE_HI = 8'h88;
	localparam logic [7:0] ETHTYPE_LO = 8'h47;

	// configuration register indexes
	localparam logic [1:0] CFG_SKIP_LABELS = 2'd0;
	localparam logic [1:0] CFG_MATCH_LABEL = 2'd1;
	localparam logic [1:0] CFG_NEW_LABEL   = 2'd2;

	typedef enum logic {
		CMD_BYTE,
		CMD_FLUSH
	} cmd_kind_t;

	// one command from front to back
	typedef struct packed {
		cmd_kind_t         kind;
		logic [7:0]        data;      // byte to emit (byte command)
		logic              last;      // frame end flag
		logic [SIDX_W-1:0] base;      // first byte of the label entry (flush)
		logic [SIDX_W-1:0] last_idx;  // last stored byte to flush
	} queue_entry_t;

	typedef struct packed {
		logic              en;
		logic [SIDX_W-1:0] addr;
		logic [7:0]        data;
	} store_wr_t;

	typedef struct packed {
		logic flush_done;
	} back_status_t;

endpackage

>>> rtl/mlrf_queue.sv
`timescale 1ns / 1ps

module mlrf_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  mlrf_pkg::queue_entry_t push_entry,
	input  logic                  pop,
	output mlrf_pkg::queue_entry_t head,
	output logic                  empty,
	output logic                  full
);

	mlrf_pkg::queue_entry_t entries_q [mlrf_pkg::QUEUE_DEPTH];
	logic [mlrf_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [mlrf_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [mlrf_pkg::QCNT_W-1:0] count_q;

	function automatic logic [mlrf_pkg::QPTR_W-1:0] ptr_next(
		input logic [mlrf_pkg::QPTR_W-1:0] p);
		if (p == mlrf_pkg::QPTR_W'(mlrf_pkg::QUEUE_DEPTH - 1))
			return '0;
		return p + 1'b1;
	endfunction

	assign empty = (count_q == '0);
	assign full  = (count_q == mlrf_pkg::QCNT_W'(mlrf_pkg::QUEUE_DEPTH));
	assign head  = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			entries_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= ptr_next(wr_ptr_q);
			if (pop)
				rd_ptr_q <= ptr_next(rd_ptr_q);
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full && !pop |-> !push)
		else $error("queue push while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop)
		else $error("queue pop while empty");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count did not follow push");

endmodule

>>> rtl/mlrf_front.sv
`timescale 1ns / 1ps

module mlrf_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [7:0]             frame_byte,
	input  logic                   frame_end,
	input  logic [2:0]             skip_labels,
	input  logic [19:0]            match_label,
	input  logic                   q_full,
	output logic                   q_push,
	output mlrf_pkg::queue_entry_t q_entry,
	output mlrf_pkg::store_wr_t    store_wr,
	input  mlrf_pkg::back_status_t back_status
);

	typedef enum logic [1:0] {
		V_COLLECT,
		V_PASS,
		V_DROP
	} verdict_t;

	localparam int PW = mlrf_pkg::POS_W;

	verdict_t        verdict_q, verdict_d;
	logic [PW-1:0]   pos_q;
	logic [19:0]     gather_q, gather_d;
	logic            flush_busy_q;

	logic            accept;
	logic            last_byte;
	logic [2:0]      skip_eff;
	logic [PW-1:0]   rel;
	logic [PW-3:0]   entry_k;
	logic [1:0]      entry_off;

	assign in_ready = !q_full && !(verdict_q == V_COLLECT && flush_busy_q);
	assign accept   = in_valid && in_ready;

	assign skip_eff  = (skip_labels > 3'(mlrf_pkg::MAX_SKIP - 1)) ?
		3'(mlrf_pkg::MAX_SKIP - 1) : skip_labels;
	assign rel       = pos_q - PW'(mlrf_pkg::STACK_START);
	assign entry_k   = rel[PW-1:2];
	assign entry_off = rel[1:0];
	assign last_byte = frame_end || (pos_q >= PW'(mlrf_pkg::MAX_FRAME_BYTES - 1));

	always_comb begin
		verdict_d = verdict_q;
		gather_d  = gather_q;
		q_push    = 1'b0;
		q_entry   = '{kind: mlrf_pkg::CMD_BYTE, data: frame_byte, last: last_byte,
			base: mlrf_pkg::SIDX_W'(mlrf_pkg::STACK_START) +
				mlrf_pkg::SIDX_W'({skip_eff, 2'b00}),
			last_idx: pos_q[mlrf_pkg::SIDX_W-1:0]};
		store_wr  = '{en: 1'b0, addr: pos_q[mlrf_pkg::SIDX_W-1:0], data: frame_byte};
		if (accept) begin
			unique case (verdict_q)
				V_COLLECT: begin
					store_wr.en = (pos_q < PW'(mlrf_pkg::STORE_DEPTH));
					if ((pos_q == PW'(12) && frame_byte != mlrf_pkg::ETHTYPE_HI) ||
					    (pos_q == PW'(13) && frame_byte != mlrf_pkg::ETHTYPE_LO)) begin
						verdict_d = V_DROP;
					end else if (pos_q >= PW'(mlrf_pkg::STACK_START)) begin
						if (entry_k < (PW-2)'(skip_eff)) begin
							if (entry_off == 2'd2 && frame_byte[0])
								verdict_d = V_DROP;
						end else if (entry_k == (PW-2)'(skip_eff)) begin
							case (entry_off)
								2'd0: gather_d = {frame_byte, 12'h000};
								2'd1: gather_d = gather_q | {8'h00, frame_byte, 4'h0};
								2'd2: gather_d = gather_q | {16'h0000, frame_byte[7:4]};
								default: begin
									if (gather_q == match_label) begin
										q_push       = 1'b1;
										q_entry.kind = mlrf_pkg::CMD_FLUSH;
										verdict_d    = last_byte ? V_DROP : V_PASS;
									end else begin
										verdict_d = V_DROP;
									end
								end
							endcase
						end
					end
				end
				V_PASS: begin
					q_push = 1'b1;
					if (last_byte)
						verdict_d = V_DROP;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			verdict_q    <= V_COLLECT;
			pos_q        <= '0;
			gather_q     <= '0;
			flush_busy_q <= 1'b0;
		end else begin
			// a flush in progress keeps the next header out of the store
			if (q_push && q_entry.kind == mlrf_pkg::CMD_FLUSH)
				flush_busy_q <= 1'b1;
			else if (back_status.flush_done)
				flush_busy_q <= 1'b0;
			if (accept) begin
				if (frame_end) begin
					verdict_q <= V_COLLECT;
					pos_q     <= '0;
					gather_q  <= '0;
				end else begin
					verdict_q <= verdict_d;
					gather_q  <= gather_d;
					if (pos_q < PW'(mlrf_pkg::MAX_FRAME_BYTES))
						pos_q <= pos_q + 1'b1;
				end
			end
		end
	end

	a_flush_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		q_push && q_entry.kind == mlrf_pkg::CMD_FLUSH |-> !flush_busy_q)
		else $error("second flush issued while one is outstanding");

	a_store_safe: assert property (@(posedge clk) disable iff (!arst_n)
		store_wr.en |-> !flush_busy_q)
		else $error("header store written during a flush");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("command pushed into a full queue");

	a_done_needs_busy: assert property (@(posedge clk) disable iff (!arst_n)
		back_status.flush_done |-> flush_busy_q)
		else $error("flush done without a flush outstanding");

endmodule

>>> rtl/mlrf_back.sv
`timescale 1ns / 1ps

module mlrf_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  mlrf_pkg::store_wr_t    store_wr,
	input  mlrf_pkg::queue_entry_t q_head,
	input  logic                   q_empty,
	output logic                   q_pop,
	output mlrf_pkg::back_status_t back_status,
	input  logic [19:0]            new_label,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [7:0]             out_byte,
	output logic                   out_end
);

	typedef enum logic [1:0] {
		SUB_NONE,
		SUB_HI,
		SUB_MID,
		SUB_LO
	} sub_t;

	localparam int SW = mlrf_pkg::SIDX_W;

	logic [7:0]    store_mem [mlrf_pkg::STORE_DEPTH];
	logic [7:0]    rdata_q;

	// flush sequencer
	logic          flush_q;
	logic [SW-1:0] idx_q;
	logic [SW-1:0] last_q;
	logic [SW-1:0] base_q;
	logic          fend_q;

	// read stage
	logic          valid_s1;
	logic          mem_s1;
	logic [7:0]    byte_s1;
	sub_t          sub_s1;
	logic          end_s1;

	logic          out_valid_q;
	logic [7:0]    out_byte_q;
	logic          out_end_q;

	logic          adv_out, move_s1, s1_free, issue_rd, pop_byte;
	sub_t          sub_rd;
	logic [7:0]    src_byte;
	logic [7:0]    fixed_byte;

	assign adv_out  = !out_valid_q || out_ready;
	assign move_s1  = valid_s1 && adv_out;
	assign s1_free  = !valid_s1 || move_s1;
	assign issue_rd = flush_q && s1_free;
	assign q_pop    = !flush_q && !q_empty && s1_free;
	assign pop_byte = q_pop && q_head.kind == mlrf_pkg::CMD_BYTE;

	assign back_status.flush_done = issue_rd && (idx_q == last_q);

	always_comb begin
		if (idx_q == base_q)
			sub_rd = SUB_HI;
		else if (idx_q == base_q + 1'b1)
			sub_rd = SUB_MID;
		else if (idx_q == base_q + 2'd2)
			sub_rd = SUB_LO;
		else
			sub_rd = SUB_NONE;
	end

	assign src_byte = mem_s1 ? rdata_q : byte_s1;

	always_comb begin
		unique case (sub_s1)
			SUB_HI:   fixed_byte = new_label[19:12];
			SUB_MID:  fixed_byte = new_label[11:4];
			SUB_LO:   fixed_byte = {new_label[3:0], src_byte[3:0]};
			default:  fixed_byte = src_byte;
		endcase
	end

	always_ff @(posedge clk) begin
		if (store_wr.en)
			store_mem[store_wr.addr] <= store_wr.data;
	end

	always_ff @(posedge clk) begin
		if (issue_rd)
			rdata_q <= store_mem[idx_q];
	end

	always_ff @(posedge clk) begin
		if (q_pop && q_head.kind == mlrf_pkg::CMD_FLUSH) begin
			last_q <= q_head.last_idx;
			base_q <= q_head.base;
			fend_q <= q_head.last;
		end
		if (issue_rd) begin
			mem_s1 <= 1'b1;
			sub_s1 <= sub_rd;
			end_s1 <= fend_q && (idx_q == last_q);
		end else if (pop_byte) begin
			mem_s1  <= 1'b0;
			byte_s1 <= q_head.data;
			sub_s1  <= SUB_NONE;
			end_s1  <= q_head.last;
		end
		if (move_s1) begin
			out_byte_q <= fixed_byte;
			out_end_q  <= end_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flush_q     <= 1'b0;
			idx_q       <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop && q_head.kind == mlrf_pkg::CMD_FLUSH) begin
				flush_q <= 1'b1;
				idx_q   <= '0;
			end else if (issue_rd) begin
				if (idx_q == last_q)
					flush_q <= 1'b0;
				idx_q <= idx_q + 1'b1;
			end
			if (issue_rd || pop_byte)
				valid_s1 <= 1'b1;
			else if (move_s1)
				valid_s1 <= 1'b0;
			if (move_s1)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_end   = out_end_q;

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		flush_q |-> idx_q <= last_q)
		else $error("flush index ran past the last stored byte");

	a_no_pop_in_flush: assert property (@(posedge clk) disable iff (!arst_n)
		flush_q |-> !q_pop)
		else $error("queue popped during a flush");

	a_read_slot: assert property (@(posedge clk) disable iff (!arst_n)
		issue_rd |-> s1_free)
		else $error("store read issued with the read stage occupied");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q && $stable(out_byte_q))
		else $error("output item changed before it was taken");

endmodule

>>> rtl/mpls_label_rewrite_filter.sv
`timescale 1ns / 1ps

// channel    | handshake            | payload
// -----------+----------------------+---------------------------------------
// input      | in_valid / in_ready  | frame_byte[7:0], frame_end
// output     | out_valid / out_ready| out_byte[7:0], out_end
// config     | cfg_we (no wait)     | cfg_index[1:0], cfg_data[19:0]
//
// one input item per cycle while the queue has room; the front stalls only at the
// start of a new frame while the previous frame's header flush is still being read
// out of the header store (single read port). a flush pops its command from the
// queue, then reads its stored bytes out of the store one by one in the back.
// asynchronous active-low reset clears control state and the config registers.
// out_ready low backs up through the output register and the command queue.

module mpls_label_rewrite_filter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  frame_byte,
	input  logic        frame_end,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        out_end,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [19:0] cfg_data
);

	// configuration registers
	logic [2:0]  skip_labels_q;
	logic [19:0] match_label_q;
	logic [19:0] new_label_q;

	// front to back plumbing
	logic                   q_push, q_pop, q_empty, q_full;
	mlrf_pkg::queue_entry_t q_entry, q_head;
	mlrf_pkg::store_wr_t    store_wr;
	mlrf_pkg::back_status_t back_status;

	// register writes, index beyond the list is ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_labels_q <= '0;
			match_label_q <= '0;
			new_label_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mlrf_pkg::CFG_SKIP_LABELS: skip_labels_q <= cfg_data[2:0];
				mlrf_pkg::CFG_MATCH_LABEL: match_label_q <= cfg_data;
				mlrf_pkg::CFG_NEW_LABEL:   new_label_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// front: header capture, ethertype and stack checks, label compare
	mlrf_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.frame_byte  (frame_byte),
		.frame_end   (frame_end),
		.skip_labels (skip_labels_q),
		.match_label (match_label_q),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_entry     (q_entry),
		.store_wr    (store_wr),
		.back_status (back_status)
	);

	// short command queue, lets the front run on while the back flushes
	mlrf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_entry),
		.pop        (q_pop),
		.head       (q_head),
		.empty      (q_empty),
		.full       (q_full)
	);

	// back: header store, flush with label rewrite, output register
	mlrf_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.store_wr    (store_wr),
		.q_head      (q_head),
		.q_empty     (q_empty),
		.q_pop       (q_pop),
		.back_status (back_status),
		.new_label   (new_label_q),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.out_end     (out_end)
	);

endmodule
